// ===== rtl/jss_pkg.sv =====
// Shared types and constants for the streaming Jacobi sweep block.
`timescale 1ns / 1ps
package jss_pkg;

	localparam int GRID_MAX_DEF = 4096;
	localparam int GRID_W       = 13;
	localparam int TEMP_W       = 24;
	localparam int SUM_W        = TEMP_W + 2;
	localparam int IDX_W        = 12;
	localparam int COOL_W       = 25;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_W        = 24;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOL_THRESHOLD = 2'd2;

	localparam logic [GRID_W-1:0] GRID_SIZE_RST      = 13'd2560;
	localparam logic [TEMP_W-1:0] EPSILON_RST        = 24'd6554;
	localparam logic [TEMP_W-1:0] COOL_THRESHOLD_RST = 24'd3276800;

	typedef struct packed {
		logic has_res;
		logic interior;
		logic last_row;
		logic done;
	} cell_flags_t;

endpackage

// ===== rtl/jacobi_stencil_sweep.sv =====
// Top level of the streaming five-point Jacobi sweep with two line stores.
// A result passes stage 1, stage 2 and the output register after its beat is taken.
// One cell per cycle unless the output stalls; each line store: two reads, one write.
// Cells of the first plate row give no result.
// Reset clears position counters, running max/cool figures, valid bits and loads
// register defaults; the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module jacobi_stencil_sweep #(
	parameter int GRID_MAX = jss_pkg::GRID_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [jss_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [jss_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          cell_valid,
	output logic                          cell_ready,
	input  logic [jss_pkg::TEMP_W-1:0]    cell_value,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [jss_pkg::TEMP_W-1:0]    new_value,
	output logic [jss_pkg::IDX_W-1:0]     out_row,
	output logic [jss_pkg::IDX_W-1:0]     out_col,
	output logic                          sweep_done,
	output logic [jss_pkg::TEMP_W-1:0]    max_change,
	output logic [jss_pkg::COOL_W-1:0]    cool_count,
	output logic                          converged
);

	localparam int AW = $clog2(GRID_MAX);
	localparam int TW = jss_pkg::TEMP_W;
	localparam int SW = jss_pkg::SUM_W;
	localparam int GW = jss_pkg::GRID_W;

	logic [GW-1:0] grid_q;
	logic [TW-1:0] eps_q;
	logic [TW-1:0] thr_q;

	logic [AW-1:0]        row;
	logic [AW-1:0]        col;
	logic [AW-1:0]        last;
	logic [AW-1:0]        col_w;
	logic [AW-1:0]        col_e;
	jss_pkg::cell_flags_t flags;

	logic                 v1_q;
	logic [TW-1:0]        x_s1;
	logic [AW-1:0]        row_s1;
	logic [AW-1:0]        col_s1;
	jss_pkg::cell_flags_t flg_s1;

	logic          take;
	logic          mv1;
	logic          s2_ready;
	logic [TW-1:0] up_n;
	logic [TW-1:0] up_w;
	logic [TW-1:0] mid_o;
	logic [TW-1:0] mid_e;
	logic [SW-1:0] sum;
	logic [TW-1:0] nv;
	logic [1:0]    cool_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= jss_pkg::GRID_SIZE_RST;
			eps_q  <= jss_pkg::EPSILON_RST;
			thr_q  <= jss_pkg::COOL_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				jss_pkg::REG_GRID_SIZE:      grid_q <= cfg_wdata[GW-1:0];
				jss_pkg::REG_EPSILON:        eps_q  <= cfg_wdata[TW-1:0];
				jss_pkg::REG_COOL_THRESHOLD: thr_q  <= cfg_wdata[TW-1:0];
				default: ;
			endcase
		end
	end

	jss_seq #(
		.GRID_MAX(GRID_MAX)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.grid_size(grid_q),
		.row      (row),
		.col      (col),
		.last     (last),
		.flags    (flags)
	);

	// a beat with no result leaves stage 1 without waiting on stage 2
	assign cell_ready = !v1_q || !flg_s1.has_res || s2_ready;
	assign take       = cell_valid && cell_ready;
	assign mv1        = v1_q && cell_ready;

	assign col_w = (col == '0) ? '0 : col - AW'(1);
	assign col_e = (col == last) ? '0 : col + AW'(1);

	// upper holds the row two above the input, middle the row just above
	jss_ram #(
		.WIDTH(TW),
		.DEPTH(GRID_MAX)
	) u_upper (
		.clk    (clk),
		.we     (mv1),
		.waddr  (col_s1),
		.wdata  (mid_o),
		.re     (take),
		.raddr_a(col),
		.raddr_b(col_w),
		.rdata_a(up_n),
		.rdata_b(up_w)
	);

	jss_ram #(
		.WIDTH(TW),
		.DEPTH(GRID_MAX)
	) u_middle (
		.clk    (clk),
		.we     (mv1),
		.waddr  (col_s1),
		.wdata  (x_s1),
		.re     (take),
		.raddr_a(col),
		.raddr_b(col_e),
		.rdata_a(mid_o),
		.rdata_b(mid_e)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (cell_ready) begin
			v1_q <= cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1   <= cell_value;
			row_s1 <= row;
			col_s1 <= col;
			flg_s1 <= flags;
		end
	end

	// west neighbor comes from upper: it was moved there one column back
	always_comb begin
		sum      = SW'(up_n) + SW'(up_w) + SW'(mid_e) + SW'(x_s1);
		nv       = flg_s1.interior ? sum[SW-1:2] : mid_o;
		cool_inc = {1'b0, (nv < thr_q)} + {1'b0, (flg_s1.last_row && x_s1 < thr_q)};
	end

	jss_stats #(
		.GRID_MAX(GRID_MAX)
	) u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (mv1 && flg_s1.has_res),
		.ready     (s2_ready),
		.nv        (nv),
		.old       (mid_o),
		.cool_inc  (cool_inc),
		.flags     (flg_s1),
		.row       (row_s1),
		.col       (col_s1),
		.epsilon   (eps_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.new_value (new_value),
		.out_row   (out_row),
		.out_col   (out_col),
		.sweep_done(sweep_done),
		.max_change(max_change),
		.cool_count(cool_count),
		.converged (converged)
	);

`ifndef ASSERT_OFF
	a_done_has_res: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && flg_s1.done |-> flg_s1.has_res && flg_s1.last_row)
		else $error("last cell of the sweep carries no result");

	a_interior_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && flg_s1.interior |-> col_s1 != '0 && row_s1 > AW'(1))
		else $error("stencil applied on a border cell");
`endif

endmodule

// ===== rtl/jss_ram.sv =====
// Generic two-read one-write RAM with registered reads and write-through bypass.
`timescale 1ns / 1ps
module jss_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// same-edge write to a read address returns the new data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a_q <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
			rdata_b_q <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ===== rtl/jss_seq.sv =====
// Raster position counters with grid size clamping and per-cell flags.
`timescale 1ns / 1ps
module jss_seq #(
	parameter int GRID_MAX = jss_pkg::GRID_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [jss_pkg::GRID_W-1:0]  grid_size,
	output logic [$clog2(GRID_MAX)-1:0] row,
	output logic [$clog2(GRID_MAX)-1:0] col,
	output logic [$clog2(GRID_MAX)-1:0] last,
	output jss_pkg::cell_flags_t        flags
);

	localparam int AW = $clog2(GRID_MAX);
	localparam int GW = jss_pkg::GRID_W;

	logic [AW-1:0] row_q;
	logic [AW-1:0] col_q;
	logic [GW-1:0] n_eff;

	always_comb begin
		if (grid_size < GW'(3)) begin
			n_eff = GW'(3);
		end else if (grid_size > GW'(GRID_MAX)) begin
			n_eff = GW'(GRID_MAX);
		end else begin
			n_eff = grid_size;
		end
		last = AW'(n_eff - GW'(1));
		// a counter left beyond the edge by a smaller grid acts as the edge
		row = (row_q < last) ? row_q : last;
		col = (col_q < last) ? col_q : last;
		flags.has_res  = (row != '0);
		flags.interior = (row > AW'(1)) && (col != '0) && (col < last);
		flags.last_row = (row == last);
		flags.done     = (row == last) && (col == last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			if (flags.done) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col == last) begin
				row_q <= row + AW'(1);
				col_q <= '0;
			end else begin
				row_q <= row;
				col_q <= col + AW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_wrap_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		take && flags.done |=> row_q == '0 && col_q == '0)
		else $error("position counters did not wrap after the last cell");
`endif

endmodule

// ===== rtl/jss_stats.sv =====
// Change tracking, cool cell count and result output register.
`timescale 1ns / 1ps
module jss_stats #(
	parameter int GRID_MAX = jss_pkg::GRID_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	output logic                        ready,
	input  logic [jss_pkg::TEMP_W-1:0]  nv,
	input  logic [jss_pkg::TEMP_W-1:0]  old,
	input  logic [1:0]                  cool_inc,
	input  jss_pkg::cell_flags_t        flags,
	input  logic [$clog2(GRID_MAX)-1:0] row,
	input  logic [$clog2(GRID_MAX)-1:0] col,
	input  logic [jss_pkg::TEMP_W-1:0]  epsilon,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [jss_pkg::TEMP_W-1:0]  new_value,
	output logic [jss_pkg::IDX_W-1:0]   out_row,
	output logic [jss_pkg::IDX_W-1:0]   out_col,
	output logic                        sweep_done,
	output logic [jss_pkg::TEMP_W-1:0]  max_change,
	output logic [jss_pkg::COOL_W-1:0]  cool_count,
	output logic                        converged
);

	localparam int AW = $clog2(GRID_MAX);
	localparam int TW = jss_pkg::TEMP_W;
	localparam int CW = jss_pkg::COOL_W;
	localparam int IW = jss_pkg::IDX_W;

	logic                 v2_q;
	logic [TW-1:0]        nv_s2;
	logic [TW-1:0]        old_s2;
	logic [1:0]           inc_s2;
	jss_pkg::cell_flags_t flg_s2;
	logic [AW-1:0]        row_s2;
	logic [AW-1:0]        col_s2;

	logic [TW-1:0] max_q;
	logic [CW-1:0] cool_q;

	logic          res_valid_q;
	logic [TW-1:0] new_value_q;
	logic [IW-1:0] out_row_q;
	logic [IW-1:0] out_col_q;
	logic          sweep_done_q;
	logic [TW-1:0] max_change_q;
	logic [CW-1:0] cool_count_q;
	logic          converged_q;

	logic          mv2;
	logic [TW-1:0] diff;
	logic [TW-1:0] max_nx;
	logic [CW-1:0] cool_nx;

	assign mv2   = v2_q && (!res_valid_q || res_ready);
	assign ready = !v2_q || mv2;

	always_comb begin
		diff    = (nv_s2 > old_s2) ? (nv_s2 - old_s2) : (old_s2 - nv_s2);
		max_nx  = (flg_s2.interior && diff > max_q) ? diff : max_q;
		cool_nx = cool_q + CW'(inc_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q        <= 1'b0;
			res_valid_q <= 1'b0;
			max_q       <= '0;
			cool_q      <= '0;
		end else begin
			if (ready) begin
				v2_q <= take;
			end
			if (!res_valid_q || res_ready) begin
				res_valid_q <= v2_q;
			end
			if (mv2) begin
				// clear the running figures once the sweep's last beat leaves
				max_q  <= flg_s2.done ? '0 : max_nx;
				cool_q <= flg_s2.done ? '0 : cool_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ready) begin
			nv_s2  <= nv;
			old_s2 <= old;
			inc_s2 <= cool_inc;
			flg_s2 <= flags;
			row_s2 <= row;
			col_s2 <= col;
		end
		if (mv2) begin
			new_value_q  <= nv_s2;
			out_row_q    <= IW'(row_s2 - AW'(1));
			out_col_q    <= IW'(col_s2);
			sweep_done_q <= flg_s2.done;
			max_change_q <= flg_s2.done ? max_nx : '0;
			cool_count_q <= flg_s2.done ? cool_nx : '0;
			converged_q  <= flg_s2.done && (max_nx <= epsilon);
		end
	end

	assign res_valid  = res_valid_q;
	assign new_value  = new_value_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign sweep_done = sweep_done_q;
	assign max_change = max_change_q;
	assign cool_count = cool_count_q;
	assign converged  = converged_q;

`ifndef ASSERT_OFF
	a_stats_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !sweep_done_q |->
			max_change_q == '0 && cool_count_q == '0 && !converged_q)
		else $error("sweep figures shown on a beat that does not end the sweep");

	a_converged: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && sweep_done_q |-> converged_q == (max_change_q <= epsilon))
		else $error("converged flag disagrees with max_change");
`endif

endmodule
